// ===== rtl/wstr_pkg.sv =====
// ----------------------------------------------------------------------------
// wstr_pkg: shared types for the WebSocket text frame receiver
// Parse phases, result kinds, opcodes and the result word layout.
// ----------------------------------------------------------------------------
package wstr_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  localparam logic [3:0]  OP_TEXT      = 4'h1;
  localparam logic [3:0]  OP_CLOSE     = 4'h8;
  localparam logic [6:0]  LEN_EXT16    = 7'd126;
  localparam logic [6:0]  LEN_EXT64    = 7'd127;
  localparam logic [2:0]  EXT16_BYTES  = 3'd2;
  localparam logic [2:0]  MASK_BYTES   = 3'd4;
  localparam int unsigned CAP_W        = 17;
  localparam logic [CAP_W-1:0] CAP_RESET = 17'h10000;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

// ===== rtl/wstr_parse.sv =====
// ----------------------------------------------------------------------------
// wstr_parse: frame header and payload parser
// Holds the parse state and decides, for each accepted byte, the next state
// and the optional result word.
// ----------------------------------------------------------------------------
module wstr_parse #(
  parameter int SKIP_LIMIT = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [7:0]                rx_byte_i,
  input  logic [wstr_pkg::CAP_W-1:0] max_bytes_i,
  output logic                      res_valid_o,
  output wstr_pkg::result_t         res_o
);
  import wstr_pkg::*;

  localparam logic [6:0] SkipLim = 7'(SKIP_LIMIT);

  phase_e             phase_q, phase_d;
  logic [3:0]         opcode_q, opcode_d;
  logic               mask_q, mask_d;
  logic [63:0]        rem_q, rem_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [CAP_W-1:0]   deliv_q, deliv_d;
  logic [6:0]         skip_q, skip_d;

  logic               len_done, hdr_done, frame_end;
  logic [2:0]         cnt_inc;
  logic [63:0]        rem_dec;
  logic [CAP_W-1:0]   cap, limit, deliv_inc;
  logic [6:0]         skip_inc;

  assign cnt_inc   = cnt_q + 3'd1;
  assign rem_dec   = rem_q - 64'd1;
  assign cap       = (max_bytes_i == '0) ? CAP_W'(1) : max_bytes_i;
  assign limit     = cap - CAP_W'(1);
  assign deliv_inc = deliv_q + CAP_W'(1);
  assign skip_inc  = skip_q + 7'd1;

  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    mask_d      = mask_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    deliv_d     = deliv_q;
    skip_d      = skip_q;
    len_done    = 1'b0;
    hdr_done    = 1'b0;
    frame_end   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_TEXT, data: 8'h00, last: 1'b0};

    case (phase_q)
      PH_HDR0: begin
        opcode_d = rx_byte_i[3:0];
        phase_d  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_d = rx_byte_i[7];
        rem_d  = '0;
        cnt_d  = '0;
        if (rx_byte_i[6:0] == LEN_EXT16) begin
          phase_d = PH_EXT16;
        end else if (rx_byte_i[6:0] == LEN_EXT64) begin
          phase_d = PH_EXT64;
        end else begin
          rem_d    = {57'd0, rx_byte_i[6:0]};
          len_done = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        rem_d = {rem_q[55:0], rx_byte_i};
        cnt_d = cnt_inc;
        // a 64-bit length ends when the 3-bit count wraps to zero
        if (phase_q == PH_EXT16) len_done = (cnt_inc == EXT16_BYTES);
        else                     len_done = (cnt_inc == 3'd0);
      end
      PH_MASK: begin
        cnt_d    = cnt_inc;
        hdr_done = (cnt_inc >= MASK_BYTES);
      end
      PH_PAYLOAD: begin
        rem_d = rem_dec;
        if (opcode_q == OP_TEXT && deliv_q < limit) begin
          deliv_d     = deliv_inc;
          res_valid_o = 1'b1;
          res_o       = '{kind: KIND_TEXT, data: rx_byte_i,
                          last: (deliv_inc == limit) || (rem_dec == '0)};
        end
        frame_end = (rem_dec == '0);
      end
      default: begin
        phase_d = PH_HDR0;
      end
    endcase

    if (len_done) begin
      if (mask_d) begin
        phase_d = PH_MASK;
        cnt_d   = '0;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      deliv_d = '0;
      if (rem_d == '0) frame_end = 1'b1;
      else             phase_d   = PH_PAYLOAD;
    end

    if (frame_end) begin
      phase_d = PH_HDR0;
      if (opcode_d == OP_TEXT) begin
        skip_d = '0;
        if (deliv_d == '0) begin
          res_valid_o = 1'b1;
          res_o       = '{kind: KIND_EMPTY, data: 8'h00, last: 1'b1};
        end
      end else if (opcode_d == OP_CLOSE) begin
        skip_d = '0;
        if (!res_valid_o) begin
          res_valid_o = 1'b1;
          res_o       = '{kind: KIND_CLOSE, data: 8'h00, last: 1'b1};
        end
      end else if (skip_inc >= SkipLim) begin
        skip_d = '0;
        if (!res_valid_o) begin
          res_valid_o = 1'b1;
          res_o       = '{kind: KIND_ERROR, data: 8'h00, last: 1'b1};
        end
      end else begin
        skip_d = skip_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      rem_q    <= '0;
      cnt_q    <= '0;
      deliv_q  <= '0;
      skip_q   <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      deliv_q  <= deliv_d;
      skip_q   <= skip_d;
    end
  end

endmodule

// ===== rtl/wstr_outq.sv =====
// ----------------------------------------------------------------------------
// wstr_outq: two-entry result queue
// Registers result words so the parser keeps taking bytes while one result
// waits at the output.
// ----------------------------------------------------------------------------
module wstr_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wstr_pkg::result_t push_word_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output wstr_pkg::result_t head_o
);
  import wstr_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_pop  = pop_i && valid_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/websocket_text_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// websocket_text_frame_receiver_core: WebSocket text frame receiver
// Parses received bytes into frames and emits text bytes and frame events.
// ----------------------------------------------------------------------------
// One received word is taken per clock cycle while in_ready_o is high: the
// whole parse step for a byte is a single pass from the parse state registers
// into a two-entry result queue. in_ready_o drops only while two results wait
// unread at the output. Text payload bytes come out with is_last on the final
// delivered byte; empty text, close and the skip limit error each come out
// as one word with is_last set. The user must write the capacity register
// via cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
module websocket_text_frame_receiver_core #(
  parameter int SKIP_LIMIT = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wstr_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [7:0]                 data_byte_o,
  output logic                       is_last_o
);
  import wstr_pkg::*;

  logic [CAP_W-1:0] max_bytes_q;
  logic             accept, res_valid, q_full;
  result_t          res, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_bytes_q <= CAP_RESET;
    else if (cfg_we_i) max_bytes_q <= cfg_wdata_i;
  end

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  wstr_parse #(
    .SKIP_LIMIT (SKIP_LIMIT)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .max_bytes_i (max_bytes_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wstr_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_word_i (res),
    .full_o      (q_full),
    .valid_o     (out_valid_o),
    .pop_i       (out_ready_i),
    .head_o      (head)
  );

  assign kind_o      = head.kind;
  assign data_byte_o = head.data;
  assign is_last_o   = head.last;

endmodule

// ===== rtl/wstr_chk.sv =====
// ----------------------------------------------------------------------------
// wstr_chk: port checker for the WebSocket text frame receiver
// Watches the result channel and the input ready over time.
// ----------------------------------------------------------------------------
module wstr_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] data_byte_o,
  input logic       is_last_o
);
  import wstr_pkg::*;

  logic mid_msg_q;

  // track a text message that has delivered words but not its last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_msg_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      mid_msg_q <= (kind_o == KIND_TEXT) && !is_last_o;
    end
  end

  a_event_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_TEXT |-> is_last_o && data_byte_o == 8'h00)
    else $error("event word without is_last or with nonzero data");

  a_msg_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mid_msg_q |-> kind_o == KIND_TEXT)
    else $error("text message interrupted before its last byte");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(data_byte_o) && $stable(is_last_o))
    else $error("result word changed while stalled");

endmodule

bind websocket_text_frame_receiver_core wstr_chk u_wstr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .data_byte_o (data_byte_o),
  .is_last_o   (is_last_o)
);
